FILE: src/qsdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ship and date query parser package
// Shared widths, character codes, the transaction record handed from the
// parser front to the checker back, and the small lookup functions.
// ----------------------------------------------------------------------------
package qsdp_pkg;

    // Width of the decimal accumulators; they wrap modulo 2^NUM_BITS.
    localparam int NUM_BITS = 32;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_S    = 8'h73;
    localparam logic [7:0] CHAR_D    = 8'h64;

    // Length of the "ship=" and "date=" prefixes.
    localparam logic [2:0] PREFIX_LEN = 3'd5;

    // Year constants.
    localparam logic [NUM_BITS-1:0] YEAR_TWO_DIGIT = NUM_BITS'(100);
    localparam logic [NUM_BITS-1:0] YEAR_BASE      = NUM_BITS'(1900);

    // Closed field as handed from the front to the back.
    typedef struct packed {
        logic                cand;   // ship and date both present at close
        logic                last;   // caused by the final byte
        logic [NUM_BITS-1:0] ship;
        logic [NUM_BITS-1:0] day;
        logic [NUM_BITS-1:0] month;
        logic [NUM_BITS-1:0] year;
    } qsdp_rec_t;

    // Expected character at a prefix position.
    function automatic logic [7:0] prefix_char(input logic is_ship, input logic [2:0] pos);
        logic [7:0] ch;
        begin
            ch = 8'h00;
            case (pos)
                3'd0:    ch = is_ship ? 8'h73 : 8'h64;  // s / d
                3'd1:    ch = is_ship ? 8'h68 : 8'h61;  // h / a
                3'd2:    ch = is_ship ? 8'h69 : 8'h74;  // i / t
                3'd3:    ch = is_ship ? 8'h70 : 8'h65;  // p / e
                3'd4:    ch = 8'h3D;                    // =
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // Number of days in a month 1..12.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        begin
            n = 5'd31;
            case (month)
                4'd2:    n = leap ? 5'd29 : 5'd28;
                4'd4:    n = 5'd30;
                4'd6:    n = 5'd30;
                4'd9:    n = 5'd30;
                4'd11:   n = 5'd30;
                default: n = 5'd31;
            endcase
            return n;
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/qsdp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Query parser front
// Accepts one byte per cycle while the queue is not full, tracks the field
// mode and prefix position, accumulates the ship number and the date parts,
// and at each field close with both present, or at the final byte, hands a record to the queue.
// ----------------------------------------------------------------------------
module qsdp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          char_in,
    input  wire logic                is_last,
    input  wire logic                q_full,
    output logic                     push,
    output qsdp_pkg::qsdp_rec_t      push_rec
);
    import qsdp_pkg::*;

    localparam logic [2:0] MODE_IDLE        = 3'd0;
    localparam logic [2:0] MODE_SHIP_PREFIX = 3'd1;
    localparam logic [2:0] MODE_SHIP_DIGITS = 3'd2;
    localparam logic [2:0] MODE_DATE_PREFIX = 3'd3;
    localparam logic [2:0] MODE_DATE_DIGITS = 3'd4;
    localparam logic [2:0] MODE_ERROR       = 3'd5;

    logic [2:0]          mode_reg, mode_next;
    logic [2:0]          pos_reg, pos_next;
    logic                ship_pres_reg, ship_pres_next;
    logic [NUM_BITS-1:0] ship_reg, ship_next;
    logic                date_pres_reg, date_pres_next;
    logic [NUM_BITS-1:0] day_reg, day_next;
    logic [NUM_BITS-1:0] month_reg, month_next;
    logic [NUM_BITS-1:0] year_reg, year_next;

    // Byte after the parser has taken it, before the close.
    logic [2:0]          mode_b;
    logic [2:0]          pos_b;
    logic                ship_pres_b;
    logic [NUM_BITS-1:0] ship_b;
    logic                date_pres_b;
    logic [NUM_BITS-1:0] day_b;
    logic [NUM_BITS-1:0] month_b;
    logic [NUM_BITS-1:0] year_b;

    logic                accept;
    logic                is_digit;
    logic [NUM_BITS-1:0] digit_val;
    logic [2:0]          pos_inc;
    logic                close;
    logic                both;

    // Decimal shift-in: acc * 10 + digit, modulo 2^NUM_BITS.
    function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] acc,
                                                      input logic [NUM_BITS-1:0] d);
        return (acc << 3) + (acc << 1) + d;
    endfunction

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign digit_val = NUM_BITS'(char_in[3:0]);
    assign pos_inc   = pos_reg + 3'd1;

    // Per-byte parsing.
    always_comb
    begin
        mode_b      = mode_reg;
        pos_b       = pos_reg;
        ship_pres_b = ship_pres_reg;
        ship_b      = ship_reg;
        date_pres_b = date_pres_reg;
        day_b       = day_reg;
        month_b     = month_reg;
        year_b      = year_reg;
        if (char_in == CHAR_AMP)
        begin
            mode_b = MODE_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (char_in == CHAR_S)
                    begin
                        mode_b = MODE_SHIP_PREFIX;
                        pos_b  = 3'd1;
                    end
                    else if (char_in == CHAR_D)
                    begin
                        mode_b = MODE_DATE_PREFIX;
                        pos_b  = 3'd1;
                    end
                    else
                    begin
                        mode_b = MODE_ERROR;
                    end
                end
                MODE_SHIP_PREFIX, MODE_DATE_PREFIX:
                begin
                    if ((pos_reg < PREFIX_LEN) &&
                        (char_in == prefix_char(mode_reg == MODE_SHIP_PREFIX, pos_reg)))
                    begin
                        pos_b = pos_inc;
                        if (pos_inc == PREFIX_LEN)
                        begin
                            pos_b = 3'd0;
                            if (mode_reg == MODE_SHIP_PREFIX)
                            begin
                                ship_pres_b = 1'b0;
                                mode_b      = MODE_SHIP_DIGITS;
                            end
                            else
                            begin
                                date_pres_b = 1'b0;
                                mode_b      = MODE_DATE_DIGITS;
                            end
                        end
                    end
                    else
                    begin
                        mode_b = MODE_ERROR;
                    end
                end
                MODE_SHIP_DIGITS:
                begin
                    if (is_digit)
                    begin
                        ship_pres_b = 1'b1;
                        ship_b = acc_digit(ship_pres_reg ? ship_reg : '0, digit_val);
                    end
                    else
                    begin
                        mode_b = MODE_ERROR;
                    end
                end
                MODE_DATE_DIGITS:
                begin
                    if (is_digit)
                    begin
                        date_pres_b = 1'b1;
                        if (!date_pres_reg)
                        begin
                            day_b   = '0;
                            month_b = '0;
                            year_b  = '0;
                        end
                        if (pos_reg == 3'd0)
                            day_b = acc_digit(day_b, digit_val);
                        else if (pos_reg == 3'd1)
                            month_b = acc_digit(month_b, digit_val);
                        else
                            year_b = acc_digit(year_b, digit_val);
                    end
                    else if (char_in == CHAR_DOT)
                    begin
                        pos_b = pos_inc;
                        if (pos_inc >= 3'd3)
                            mode_b = MODE_ERROR;
                    end
                    else
                    begin
                        mode_b = MODE_ERROR;
                    end
                end
                default:
                begin
                    mode_b = mode_reg;
                end
            endcase
        end
    end

    // Field close and end-of-query reset.
    assign close = (char_in == CHAR_AMP) || is_last;
    assign both  = ship_pres_b && date_pres_b;

    always_comb
    begin
        mode_next      = mode_b;
        pos_next       = pos_b;
        ship_pres_next = ship_pres_b;
        ship_next      = ship_b;
        date_pres_next = date_pres_b;
        day_next       = day_b;
        month_next     = month_b;
        year_next      = year_b;
        if (close)
        begin
            mode_next = MODE_IDLE;
            if (both)
                date_pres_next = 1'b0;
        end
        if (is_last)
        begin
            pos_next       = 3'd0;
            ship_pres_next = 1'b0;
            ship_next      = '0;
            date_pres_next = 1'b0;
            day_next       = '0;
            month_next     = '0;
            year_next      = '0;
        end
    end

    // Record handed to the back.
    assign push           = accept && ((close && both) || is_last);
    assign push_rec.cand  = close && both;
    assign push_rec.last  = is_last;
    assign push_rec.ship  = ship_b;
    assign push_rec.day   = day_b;
    assign push_rec.month = month_b;
    assign push_rec.year  = year_b;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pos_reg       <= 3'd0;
            ship_pres_reg <= 1'b0;
            ship_reg      <= '0;
            date_pres_reg <= 1'b0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            ship_pres_reg <= ship_pres_next;
            ship_reg      <= ship_next;
            date_pres_reg <= date_pres_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/qsdp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front-to-back queue
// A small first-in first-out buffer of closed-field records that lets the
// parser front and the checker back stall independently.
// ----------------------------------------------------------------------------
module qsdp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire qsdp_pkg::qsdp_rec_t push_rec,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output qsdp_pkg::qsdp_rec_t      head_rec
);
    import qsdp_pkg::*;

    qsdp_rec_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = entry_reg[rd_ptr_reg];

    // Occupancy update.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            if (pop)
                rd_ptr_reg <= QPTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule
`default_nettype wire

FILE: src/qsdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date checker back
// Three-stage pipeline: year adjustment and range checks, a reciprocal
// multiply for the divide-by-25 test, then the leap-year and month-length
// check into the output register.
// ----------------------------------------------------------------------------
module qsdp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire qsdp_pkg::qsdp_rec_t head_rec,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     pair_valid,
    output logic [31:0]              ship_number,
    output logic signed [15:0]       year_out,
    output logic [3:0]               month_out,
    output logic [4:0]               day_out,
    output logic                     end_of_query
);
    import qsdp_pkg::*;

    // Reciprocal of 25 scaled by 2^17; exact for magnitudes below 2^15.
    localparam logic [12:0] RECIP25 = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    logic a_ready, b_ready, o_ready;

    // Stage A registers.
    logic        a_valid_reg;
    logic        a_ok_reg;
    logic        a_last_reg;
    logic [31:0] a_ship_reg;
    logic [15:0] a_year_reg;
    logic [14:0] a_mag_reg;
    logic [3:0]  a_month_reg;
    logic [4:0]  a_day_reg;

    // Stage B registers.
    logic        b_valid_reg;
    logic        b_ok_reg;
    logic        b_last_reg;
    logic [31:0] b_ship_reg;
    logic [15:0] b_year_reg;
    logic [14:0] b_mag_reg;
    logic [3:0]  b_month_reg;
    logic [4:0]  b_day_reg;
    logic [10:0] b_quot_reg;

    // Output registers.
    logic        o_valid_reg;
    logic        o_pair_reg;
    logic        o_last_reg;
    logic [31:0] o_ship_reg;
    logic [15:0] o_year_reg;
    logic [3:0]  o_month_reg;
    logic [4:0]  o_day_reg;

    // Stage A combinational signals.
    logic [NUM_BITS-1:0] year_adj;
    logic [15:0]         year16;
    logic [15:0]         year_neg;
    logic                year_min;
    logic                range_ok;
    logic [63:0]         ship_wide;

    // Stage B and output combinational signals.
    logic [27:0] quot_prod;
    logic [15:0] rem25;
    logic        div4, div16, div25, leap;
    logic        date_ok;

    // Handshake between the stages.
    assign o_ready = !o_valid_reg || !out_stall;
    assign b_ready = !b_valid_reg || o_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = !empty && a_ready;

    // Stage A: 1900 adjustment, sign magnitude and range checks.
    assign year_adj  = (head_rec.year < YEAR_TWO_DIGIT) ? head_rec.year + YEAR_BASE
                                                        : head_rec.year;
    assign year16    = year_adj[15:0];
    assign year_neg  = 16'd0 - year16;
    assign year_min  = (year16 == 16'h8000);
    assign range_ok  = head_rec.cand && !year_min
                       && (head_rec.month >= NUM_BITS'(1)) && (head_rec.month <= NUM_BITS'(12))
                       && (head_rec.day >= NUM_BITS'(1)) && (head_rec.day <= NUM_BITS'(31));
    assign ship_wide = 64'(head_rec.ship);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= !empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_ok_reg    <= range_ok;
            a_last_reg  <= head_rec.last;
            a_ship_reg  <= ship_wide[31:0];
            a_year_reg  <= year16;
            a_mag_reg   <= year16[15] ? year_neg[14:0] : year16[14:0];
            a_month_reg <= head_rec.month[3:0];
            a_day_reg   <= head_rec.day[4:0];
        end
    end

    // Stage B: quotient of the year magnitude by 25.
    assign quot_prod = 28'(a_mag_reg) * 28'(RECIP25);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_ok_reg    <= a_ok_reg;
            b_last_reg  <= a_last_reg;
            b_ship_reg  <= a_ship_reg;
            b_year_reg  <= a_year_reg;
            b_mag_reg   <= a_mag_reg;
            b_month_reg <= a_month_reg;
            b_day_reg   <= a_day_reg;
            b_quot_reg  <= quot_prod[27:RECIP_SHIFT];
        end
    end

    // Output stage: leap year and month length.
    assign rem25   = 16'(b_mag_reg) - 16'(b_quot_reg) * 16'd25;
    assign div25   = (rem25 == 16'd0);
    assign div4    = (b_mag_reg[1:0] == 2'd0);
    assign div16   = (b_mag_reg[3:0] == 4'd0);
    assign leap    = div4 && (!div25 || div16);
    assign date_ok = b_ok_reg && (b_day_reg <= month_days(b_month_reg, leap));

    // A closed field whose date fails the checks yields no transaction
    // unless it also ends the query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= b_valid_reg && (date_ok || b_last_reg);
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && b_valid_reg)
        begin
            o_pair_reg  <= date_ok;
            o_last_reg  <= b_last_reg;
            o_ship_reg  <= date_ok ? b_ship_reg : 32'd0;
            o_year_reg  <= date_ok ? b_year_reg : 16'd0;
            o_month_reg <= date_ok ? b_month_reg : 4'd0;
            o_day_reg   <= date_ok ? b_day_reg : 5'd0;
        end
    end

    assign out_valid    = o_valid_reg;
    assign pair_valid   = o_pair_reg;
    assign ship_number  = o_ship_reg;
    assign year_out     = o_year_reg;
    assign month_out    = o_month_reg;
    assign day_out      = o_day_reg;
    assign end_of_query = o_last_reg;

endmodule
`default_nettype wire

FILE: src/query_ship_date_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ship and date query parser, top level
// Parses '&'-separated "ship=" and "date=" fields of a byte stream and emits
// each ship number with a calendar-checked date.
//
// Input channel: one byte (char_in) with is_last marking the final byte of
// a query; a transaction completes when in_valid is high and in_stall low.
// Output channel: pair_valid, ship_number, year_out, month_out, day_out and
// end_of_query; a transaction completes when out_valid is high and
// out_stall low. A result comes at each field close that has both a ship
// number and a date that passes the calendar check, and always for the
// final byte of a query.
// Throughput: one byte per cycle while in_stall is low; the parser state
// is registered per byte and the checker pipeline takes one record per cycle
// while the output is not stalled. A result is registered in the queue, the
// two check stages and the output register after the byte that causes it.
// Stall: the output register holds its transaction; the check stages and the
// four-entry queue fill behind it, and in_stall rises when the queue is full.
// Reset: the parser returns to idle with no ship number or date held, and
// the queue and pipeline are emptied; the block is ready at once.
// ----------------------------------------------------------------------------
module query_ship_date_parser_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         char_in,
    input  wire logic               is_last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    pair_valid,
    output logic [31:0]             ship_number,
    output logic signed [15:0]      year_out,
    output logic [3:0]              month_out,
    output logic [4:0]              day_out,
    output logic                    end_of_query
);
    import qsdp_pkg::*;

    logic      q_full;
    logic      q_empty;
    logic      push;
    logic      pop;
    qsdp_rec_t push_rec;
    qsdp_rec_t head_rec;

    // Byte parser.
    qsdp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .char_in  (char_in),
        .is_last  (is_last),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    // Decoupling queue.
    qsdp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_rec (head_rec)
    );

    // Date checker and output register.
    qsdp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .head_rec     (head_rec),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pair_valid   (pair_valid),
        .ship_number  (ship_number),
        .year_out     (year_out),
        .month_out    (month_out),
        .day_out      (day_out),
        .end_of_query (end_of_query)
    );

endmodule
`default_nettype wire
